// ===== design/gpad_pkg.sv =====
// Shared types and constants for the gamepad press-edge and dead-zone core.
package gpad_pkg;

   localparam int BTN_W           = 16;
   localparam int AXIS_W          = 8;
   localparam int OUT_W           = 16;
   localparam int DZ_W            = 7;
   localparam int FRAC_BITS       = 14;
   localparam int NUM_AXES        = 4;
   localparam int NUM_BUTTONS_DEF = 16;

   typedef struct packed {
      logic        [BTN_W-1:0]  buttons_held;
      logic signed [AXIS_W-1:0] axis_left_x;
      logic signed [AXIS_W-1:0] axis_left_y;
      logic signed [AXIS_W-1:0] axis_right_x;
      logic signed [AXIS_W-1:0] axis_right_y;
   } req_type;

   typedef struct packed {
      logic        [BTN_W-1:0] held_bits;
      logic        [BTN_W-1:0] newpress_bits;
      logic signed [OUT_W-1:0] left_x_scaled;
      logic signed [OUT_W-1:0] left_y_scaled;
      logic signed [OUT_W-1:0] right_x_scaled;
      logic signed [OUT_W-1:0] right_y_scaled;
   } rsp_type;

   // Request to the shared divider: numerator never exceeds denominator.
   typedef struct packed {
      logic              start;
      logic [AXIS_W-1:0] numer;
      logic [AXIS_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [FRAC_BITS:0]   quot;
   } div_rsp_type;

endpackage

// ===== design/gpad_div.sv =====
// Iterative restoring divider giving floor(numer * 2^FRAC_BITS / denom), one bit a cycle.
module gpad_div
   import gpad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(FRAC_BITS);

   logic [AXIS_W-1:0]  rem_ff, rem_in;
   logic [AXIS_W-1:0]  den_ff;
   logic [FRAC_BITS:0] quot_ff, quot_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [AXIS_W:0]    rem_shift;
   logic [AXIS_W:0]    rem_diff;
   logic               fits;
   logic               whole;

   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = (rem_shift >= {1'b0, den_ff});
      rem_in    = fits ? rem_diff[AXIS_W-1:0] : rem_shift[AXIS_W-1:0];
      quot_in   = {quot_ff[FRAC_BITS-1:0], fits};
      whole     = (div_req.numer >= div_req.denom);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            // The integer part is 0 or 1 since the numerator never exceeds the denominator.
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            den_ff  <= div_req.denom;
            rem_ff  <= whole ? AXIS_W'(div_req.numer - div_req.denom) : div_req.numer;
            quot_ff <= {{FRAC_BITS{1'b0}}, whole};
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= quot_in;
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ===== design/gamepad_press_edge_and_deadzone_core.sv =====
// Top level of the gamepad press-edge detector and stick dead-zone rescaler.
//
// One request transaction carries a controller poll: 16 held-button bits and
// four signed 8-bit stick axes. One response transaction follows for each
// request, carrying the held bits, the newly pressed bits (held now and not at
// the previous poll) and the four dead-zone corrected axes in Q1.14.
// The dead zone is a 7-bit register written through csr_wr_en/csr_wr_data; it
// must only change while the core is idle.
// A single restoring divider is shared by the four axes in turn. Each axis
// passes through an issue state, one divider step per fraction bit and a
// wait state that collects its result. The response register is loaded once
// the last axis is collected and the receiver is free; only then is a new request accepted.
// The divider's one quotient bit per cycle sets the length of each poll.
// req_stall stays high while a poll is in progress. The response register
// holds its transaction while rsp_stall is high; the core may accept the next
// poll meanwhile, but does not overwrite the waiting response.
// Synchronous reset clears the previous-held bits, the dead zone, the state
// machine and the response valid.
module gamepad_press_edge_and_deadzone_core
   import gpad_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_payload,
   input  logic            csr_wr_en,
   input  logic [DZ_W-1:0] csr_wr_data
);

   localparam int AX_IDX_W = $clog2(NUM_AXES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [DZ_W-1:0]        dz_ff;
   logic [BTN_W-1:0]       prev_held_ff;
   logic [BTN_W-1:0]       held_ff;
   logic [BTN_W-1:0]       fresh_ff;
   req_type                req_ff;
   logic [AX_IDX_W-1:0]    axis_ff, axis_in;
   logic signed [OUT_W-1:0] scaled_ff [NUM_AXES];
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [BTN_W-1:0]       btn_mask;
   logic                   req_take;
   logic                   rsp_free;
   logic [AXIS_W-1:0]      raw;
   logic                   neg;
   logic [AXIS_W-1:0]      mag;
   logic [AXIS_W-1:0]      dz_ext;
   logic [OUT_W-1:0]       quot_ext;
   logic [OUT_W-1:0]       result;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   // Buttons at or beyond NUM_BUTTONS never report a new press.
   always_comb begin
      for (int i = 0; i < BTN_W; i++) begin
         btn_mask[i] = (i < NUM_BUTTONS);
      end
   end

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Pick the axis under work from the captured poll.
   always_comb begin
      case (axis_ff)
         2'd0:    raw = req_ff.axis_left_x;
         2'd1:    raw = req_ff.axis_left_y;
         2'd2:    raw = req_ff.axis_right_x;
         default: raw = req_ff.axis_right_y;
      endcase
   end

   // Magnitude runs 0..128, which still fits unsigned in eight bits.
   always_comb begin
      neg           = raw[AXIS_W-1];
      mag           = neg ? AXIS_W'(~raw + 1'b1) : raw;
      dz_ext        = {1'b0, dz_ff};
      div_req.start = (state_ff == ST_ISSUE);
      div_req.numer = (mag < dz_ext) ? '0 : AXIS_W'(mag - dz_ext);
      div_req.denom = AXIS_W'((1 << (AXIS_W - 1)) - int'(dz_ext));
      quot_ext      = OUT_W'(div_rsp.quot);
      result        = neg ? OUT_W'(~quot_ext + 1'b1) : quot_ext;
   end

   gpad_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_ISSUE;
               axis_in  = '0;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               if (axis_ff == AX_IDX_W'(NUM_AXES - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ISSUE;
                  axis_in  = axis_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         dz_ff        <= '0;
         prev_held_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         if (csr_wr_en) begin
            dz_ff <= csr_wr_data;
         end
         if (req_take) begin
            req_ff       <= req_payload;
            held_ff      <= req_payload.buttons_held;
            fresh_ff     <= req_payload.buttons_held & ~prev_held_ff & btn_mask;
            prev_held_ff <= req_payload.buttons_held;
         end
         if (state_ff == ST_WAIT && div_rsp.done) begin
            scaled_ff[axis_ff] <= result;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff          <= 1'b1;
            rsp_ff.held_bits      <= held_ff;
            rsp_ff.newpress_bits  <= fresh_ff;
            rsp_ff.left_x_scaled  <= scaled_ff[0];
            rsp_ff.left_y_scaled  <= scaled_ff[1];
            rsp_ff.right_x_scaled <= scaled_ff[2];
            rsp_ff.right_y_scaled <= scaled_ff[3];
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
